FILE: sv/fmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmm_pkg: shared types, constants and binary32 helpers
// Word formats between the top level and the column cells, plus the
// unpack, leading-zero and rounding functions used by every cell.
// ----------------------------------------------------------------------------
package fmm_pkg;

    // Row/column index carried on the internal buses (wide enough for 32x32)
    typedef logic [4:0] t_idx;

    // Last value of the A issue phase counter; an A element is issued at phase 0
    localparam logic [3:0] PHASE_LAST = 4'd8;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

    // Reset value of the output row stride, and width of the output index
    localparam logic [15:0] STRIDE_RST = 16'd16;
    localparam int          OIDX_W     = 20;

    // B element write, broadcast to all column cells
    typedef struct packed {
        logic        en;
        t_idx        row;
        t_idx        col;
        logic [31:0] data;
    } t_b_wr;

    // A element token travelling down the cell chain
    typedef struct packed {
        logic        vld;
        t_idx        k;
        logic [31:0] a;
    } t_a_tok;

    function automatic logic f_is_nan(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(logic [31:0] x);
        return x[30:0] == INF_MAG;
    endfunction

    function automatic logic f_is_zero(logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // Biased exponent, subnormals read as 1
    function automatic logic [7:0] f_exp(logic [31:0] x);
        return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    endfunction

    // Significand with hidden bit
    function automatic logic [23:0] f_man(logic [31:0] x);
        return {(x[30:23] != 8'd0), x[22:0]};
    endfunction

    // Leading zero count of a nonzero 48-bit word
    function automatic logic [5:0] f_lzc48(logic [47:0] sig);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (sig[i]) begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    // Round to nearest even; sig has its leading one at bit 47
    function automatic logic [31:0] f_round48(logic sgn, logic signed [10:0] e,
                                               logic [47:0] sig);
        logic signed [11:0] sh_s;
        logic [5:0]         sh;
        logic [47:0]        keep;
        logic [47:0]        mask;
        logic               guard;
        logic               sticky;
        logic [7:0]         em1;
        logic [31:0]        res;
        if (e >= 11'sd255) begin
            res = {sgn, INF_MAG};
        end else begin
            sh_s = (e >= 11'sd1) ? 12'sd24 : (12'sd25 - {e[10], e});
            if (sh_s > 12'sd48) begin
                res = {sgn, 31'd0};
            end else begin
                sh     = 6'(sh_s);
                keep   = sig >> sh;
                guard  = sig[sh - 6'd1];
                mask   = (48'd1 << (sh - 6'd1)) - 48'd1;
                sticky = |(sig & mask);
                keep   = keep + 48'(guard & (sticky | keep[0]));
                if (e >= 11'sd1) begin
                    em1 = 8'(e - 11'sd1);
                    res = {sgn, 31'({em1, 23'd0} + keep[30:0])};
                end else begin
                    res = {sgn, keep[30:0]};
                end
            end
        end
        return res;
    endfunction

endpackage

FILE: sv/fp32_matrix_multiply_16x16.sv
`timescale 1ns / 1ps
// After the last A word of a row, the row goes down the cell chain; each cell
//   does a multiply-add per element, and the first result is valid once the
//   last of the DIM cells is done. Results leave one per cycle while the sink
//   is ready. Words are taken one per cycle while loading; a completed A row
//   holds off input until its DIM results are delivered. Reset (synchronous,
//   active low) clears B to zero, both positions, and the stride to 16.
// ----------------------------------------------------------------------------
// fp32_matrix_multiply_16x16: binary32 matrix multiply C = A x B
// B is held in a chain of column cells; each A row is streamed down the
// chain one element per step and every cell accumulates its own column.
// ----------------------------------------------------------------------------
module fp32_matrix_multiply_16x16 #(
    parameter int DIM = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: out_row_stride
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [0:0]  s_axis_tuser,   // [0] operation (0 = B, 1 = A)
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] c_value, [51:32] out_index
    output logic        m_axis_tlast    // last_in_row
);

    localparam int KW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int OW = fmm_pkg::OIDX_W;

    typedef enum logic [3:0] {
        T_LOAD = 4'b0001,
        T_RUN  = 4'b0010,
        T_WAIT = 4'b0100,
        T_OUT  = 4'b1000
    } t_top_state;

    t_top_state      r_state;
    logic [15:0]     r_stride;
    logic [KW-1:0]   r_b_row, r_b_col, r_a_row, r_a_col;
    logic [31:0]     r_rowbuf [DIM];
    logic [OW-1:0]   r_base;
    logic [KW-1:0]   r_k;
    logic [3:0]      r_phase;
    logic [KW-1:0]   r_j;
    logic            r_all;
    logic            r_ovalid;
    logic [31:0]     r_oval;
    logic [OW-1:0]   r_oidx;
    logic            r_olast;

    logic            w_acc_in;
    logic            w_load;
    fmm_pkg::t_b_wr  w_bwr;
    fmm_pkg::t_a_tok w_issue;
    fmm_pkg::t_a_tok w_tok [DIM];
    logic [31:0]     w_acc [DIM];
    logic [DIM-1:0]  w_done;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == T_LOAD);
    assign w_acc_in      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_oidx, r_oval};
    assign m_axis_tlast  = r_olast;
    assign w_load        = (r_state == T_OUT) && !r_all && (!r_ovalid || m_axis_tready);

    // B write broadcast and A token issue
    always_comb begin
        w_bwr.en    = w_acc_in && !s_axis_tuser[0];
        w_bwr.row   = fmm_pkg::t_idx'(r_b_row);
        w_bwr.col   = fmm_pkg::t_idx'(r_b_col);
        w_bwr.data  = s_axis_tdata;
        w_issue.vld = (r_state == T_RUN) && (r_phase == 4'd0);
        w_issue.k   = fmm_pkg::t_idx'(r_k);
        w_issue.a   = r_rowbuf[r_k];
    end

    // Chain of column cells
    for (genvar c = 0; c < DIM; c++) begin : g_cell
        fmm_cell #(
            .DIM (DIM),
            .COL (c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bwr   (w_bwr),
            .i_tok   ((c == 0) ? w_issue : w_tok[(c == 0) ? 0 : c - 1]),
            .o_tok   (w_tok[c]),
            .o_acc   (w_acc[c]),
            .o_done  (w_done[c])
        );
    end

    // Stride register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= fmm_pkg::STRIDE_RST;
        end else if (i_cfg_valid) begin
            r_stride <= i_cfg_data;
        end
    end

    // Load, run, wait and drain sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_LOAD;
            r_b_row  <= '0;
            r_b_col  <= '0;
            r_a_row  <= '0;
            r_a_col  <= '0;
            r_k      <= '0;
            r_phase  <= 4'd0;
            r_j      <= '0;
            r_all    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                T_LOAD: begin
                    if (w_acc_in && !s_axis_tuser[0]) begin
                        if (r_b_col == KW'(DIM - 1)) begin
                            r_b_col <= '0;
                            r_b_row <= (r_b_row == KW'(DIM - 1)) ? '0 : r_b_row + 1'b1;
                        end else begin
                            r_b_col <= r_b_col + 1'b1;
                        end
                    end else if (w_acc_in) begin
                        r_rowbuf[r_a_col] <= s_axis_tdata;
                        if (r_a_col == KW'(DIM - 1)) begin
                            r_a_col <= '0;
                            r_a_row <= (r_a_row == KW'(DIM - 1)) ? '0 : r_a_row + 1'b1;
                            r_base  <= OW'(r_a_row) * OW'(r_stride);
                            r_k     <= '0;
                            r_phase <= 4'd0;
                            r_state <= T_RUN;
                        end else begin
                            r_a_col <= r_a_col + 1'b1;
                        end
                    end
                end
                T_RUN: begin
                    if ((r_phase == 4'd0) && (r_k == KW'(DIM - 1))) begin
                        r_state <= T_WAIT;
                    end else if (r_phase == fmm_pkg::PHASE_LAST) begin
                        r_phase <= 4'd0;
                        r_k     <= r_k + 1'b1;
                    end else begin
                        r_phase <= r_phase + 4'd1;
                    end
                end
                T_WAIT: begin
                    if (w_done[DIM-1]) begin
                        r_j     <= '0;
                        r_all   <= 1'b0;
                        r_state <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (r_ovalid && m_axis_tready) begin
                        r_ovalid <= 1'b0;
                    end
                    if (w_load) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= w_acc[r_j];
                        r_oidx   <= OW'(r_base + OW'(r_j));
                        r_olast  <= (r_j == KW'(DIM - 1));
                        r_j      <= r_j + 1'b1;
                        r_all    <= (r_j == KW'(DIM - 1));
                    end
                    if (r_all && (!r_ovalid || m_axis_tready)) begin
                        r_state <= T_LOAD;
                    end
                end
                default: r_state <= T_LOAD;
            endcase
        end
    end

endmodule

FILE: sv/fmm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmm_cell: one column of the product
// Holds column COL of B, accumulates sum_k A[k]*B[k][COL] with a shared
// normalize/round unit, and forwards each A token to the next cell.
// ----------------------------------------------------------------------------
module fmm_cell #(
    parameter int DIM = 16,
    parameter int COL = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fmm_pkg::t_b_wr  i_bwr,
    input  fmm_pkg::t_a_tok i_tok,
    output fmm_pkg::t_a_tok o_tok,
    output logic [31:0]     o_acc,
    output logic            o_done
);

    localparam int KW = (DIM > 1) ? $clog2(DIM) : 1;

    typedef enum logic [5:0] {
        C_IDLE = 6'b000001,
        C_MUL  = 6'b000010,
        C_LZC  = 6'b000100,
        C_SHF  = 6'b001000,
        C_RND  = 6'b010000,
        C_ADD  = 6'b100000
    } t_cell_state;

    t_cell_state        r_state;
    fmm_pkg::t_a_tok    r_tok;
    logic [31:0]        r_col_mem [DIM];
    logic [DIM-1:0]     r_col_vld;
    logic [31:0]        r_a;
    logic [31:0]        r_b;
    logic [KW-1:0]      r_k;
    logic [31:0]        r_prod;
    logic [31:0]        r_acc;
    logic               r_sgn;
    logic signed [10:0] r_exp;
    logic [47:0]        r_sig;
    logic [5:0]         r_lz;
    logic               r_in_add;
    logic               r_done;

    logic [KW-1:0]      w_tok_k;
    logic [KW-1:0]      w_wr_row;

    // multiplier terms
    logic               m_spec;
    logic [31:0]        m_val;
    logic               m_sgn;
    logic [23:0]        m_ma;
    logic [23:0]        m_mb;
    logic [47:0]        m_prod;
    logic signed [10:0] m_exp;

    // adder terms
    logic               a_spec;
    logic [31:0]        a_val;
    logic               a_sgn;
    logic [47:0]        a_sig;
    logic signed [10:0] a_exp;
    logic [7:0]         ex, ey, big_e, sml_e, d;
    logic [27:0]        big_m, sml_m, al;
    logic               big_s, sml_s;
    logic [28:0]        sum;

    logic [31:0]        w_rnd;

    assign w_tok_k  = i_tok.k[KW-1:0];
    assign w_wr_row = i_bwr.row[KW-1:0];
    assign o_tok    = r_tok;
    assign o_acc    = r_acc;
    assign o_done   = r_done;
    assign w_rnd    = fmm_pkg::f_round48(r_sgn, r_exp, r_sig);

    // Column store of B; entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_vld <= '0;
        end else if (i_bwr.en && (i_bwr.col[KW-1:0] == KW'(COL))) begin
            r_col_vld[w_wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bwr.en && (i_bwr.col[KW-1:0] == KW'(COL))) begin
            r_col_mem[w_wr_row] <= i_bwr.data;
        end
    end

    // Product: special operands, else raw significand product
    always_comb begin
        m_sgn  = r_a[31] ^ r_b[31];
        m_ma   = fmm_pkg::f_man(r_a);
        m_mb   = fmm_pkg::f_man(r_b);
        m_prod = m_ma * m_mb;
        m_exp  = $signed({3'b000, fmm_pkg::f_exp(r_a)})
               + $signed({3'b000, fmm_pkg::f_exp(r_b)}) - 11'sd126;
        m_spec = 1'b1;
        priority if (fmm_pkg::f_is_nan(r_a) || fmm_pkg::f_is_nan(r_b)) begin
            m_val = fmm_pkg::CANON_NAN;
        end else if (fmm_pkg::f_is_inf(r_a) || fmm_pkg::f_is_inf(r_b)) begin
            if (fmm_pkg::f_is_zero(r_a) || fmm_pkg::f_is_zero(r_b)) begin
                m_val = fmm_pkg::CANON_NAN;
            end else begin
                m_val = {m_sgn, fmm_pkg::INF_MAG};
            end
        end else if (fmm_pkg::f_is_zero(r_a) || fmm_pkg::f_is_zero(r_b)) begin
            m_val = {m_sgn, 31'd0};
        end else begin
            m_val  = 32'd0;
            m_spec = 1'b0;
        end
    end

    // Sum: special operands, else align with sticky and add
    always_comb begin
        ex    = fmm_pkg::f_exp(r_acc);
        ey    = fmm_pkg::f_exp(r_prod);
        if (ex < ey) begin
            big_e = ey;  big_m = {fmm_pkg::f_man(r_prod), 4'd0};  big_s = r_prod[31];
            sml_e = ex;  sml_m = {fmm_pkg::f_man(r_acc), 4'd0};   sml_s = r_acc[31];
        end else begin
            big_e = ex;  big_m = {fmm_pkg::f_man(r_acc), 4'd0};   big_s = r_acc[31];
            sml_e = ey;  sml_m = {fmm_pkg::f_man(r_prod), 4'd0};  sml_s = r_prod[31];
        end
        d = big_e - sml_e;
        if (d >= 8'd28) begin
            al = (sml_m != 28'd0) ? 28'd1 : 28'd0;
        end else begin
            al = (sml_m >> d)
               | 28'((sml_m & ((28'd1 << d) - 28'd1)) != 28'd0);
        end
        if (big_s == sml_s) begin
            sum   = {1'b0, big_m} + {1'b0, al};
            a_sgn = big_s;
        end else if (big_m >= al) begin
            sum   = {1'b0, big_m} - {1'b0, al};
            a_sgn = big_s;
        end else begin
            sum   = {1'b0, al} - {1'b0, big_m};
            a_sgn = sml_s;
        end
        a_sig  = {sum, 19'd0};
        a_exp  = $signed({3'b000, big_e}) + 11'sd1;
        a_spec = 1'b1;
        priority if (fmm_pkg::f_is_nan(r_acc) || fmm_pkg::f_is_nan(r_prod)) begin
            a_val = fmm_pkg::CANON_NAN;
        end else if (fmm_pkg::f_is_inf(r_acc)) begin
            if (fmm_pkg::f_is_inf(r_prod) && (r_acc[31] != r_prod[31])) begin
                a_val = fmm_pkg::CANON_NAN;
            end else begin
                a_val = r_acc;
            end
        end else if (fmm_pkg::f_is_inf(r_prod)) begin
            a_val = r_prod;
        end else if (fmm_pkg::f_is_zero(r_acc)) begin
            a_val = fmm_pkg::f_is_zero(r_prod) ? {r_acc[31] & r_prod[31], 31'd0} : r_prod;
        end else if (fmm_pkg::f_is_zero(r_prod)) begin
            a_val = r_acc;
        end else if (sum == 29'd0) begin
            a_val = 32'd0;
        end else begin
            a_val  = 32'd0;
            a_spec = 1'b0;
        end
    end

    // Sequencer: multiply, normalize, round, add, normalize, round; a special product or sum skips normalize and round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_tok   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_tok  <= i_tok;
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_tok.vld) begin
                        r_a     <= i_tok.a;
                        r_b     <= r_col_vld[w_tok_k] ? r_col_mem[w_tok_k] : 32'd0;
                        r_k     <= w_tok_k;
                        if (w_tok_k == KW'(0)) begin
                            r_acc <= 32'd0;
                        end
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    r_in_add <= 1'b0;
                    if (m_spec) begin
                        r_prod  <= m_val;
                        r_state <= C_ADD;
                    end else begin
                        r_sgn   <= m_sgn;
                        r_exp   <= m_exp;
                        r_sig   <= m_prod;
                        r_state <= C_LZC;
                    end
                end
                C_LZC: begin
                    r_lz    <= fmm_pkg::f_lzc48(r_sig);
                    r_state <= C_SHF;
                end
                C_SHF: begin
                    r_sig   <= r_sig << r_lz;
                    r_exp   <= r_exp - $signed({5'd0, r_lz});
                    r_state <= C_RND;
                end
                C_RND: begin
                    if (r_in_add) begin
                        r_acc   <= w_rnd;
                        r_done  <= (r_k == KW'(DIM - 1));
                        r_state <= C_IDLE;
                    end else begin
                        r_prod  <= w_rnd;
                        r_state <= C_ADD;
                    end
                end
                C_ADD: begin
                    r_in_add <= 1'b1;
                    if (a_spec) begin
                        r_acc   <= a_val;
                        r_done  <= (r_k == KW'(DIM - 1));
                        r_state <= C_IDLE;
                    end else begin
                        r_sgn   <= a_sgn;
                        r_exp   <= a_exp;
                        r_sig   <= a_sig;
                        r_state <= C_LZC;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/fmm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmm_checker: port-level checks for the matrix multiply
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module fmm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // no input taken while a row is being delivered
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready during result delivery");

    // results of one row follow back to back with consecutive indices
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[51:32] == $past(m_axis_tdata[51:32]) + 20'd1))
        else $error("row results not consecutive");

    // after the last result of a row the block returns to loading
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
            !m_axis_tvalid && s_axis_tready)
        else $error("block did not return to loading after a row");

endmodule

bind fp32_matrix_multiply_16x16 fmm_checker u_fmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
